/* design/bpc_pkg.sv */
// Shared types and constants for the barometric pressure compensation core.
// No dependencies; imported by every module of the block.
`default_nettype none

package bpc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CalW    = 16;
  localparam int unsigned RawW    = 24;
  localparam int unsigned PressW  = 32;
  localparam int unsigned TempW   = 19;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSens     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOff      = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSensTco  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegOffTco   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTref     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTempCoef = 3'd5;

  // 20.00 degC and -15.00 degC thresholds in centidegrees
  localparam logic signed [19:0] TempRef   = 20'sd2000;
  localparam logic signed [19:0] ColdLimit = -20'sd1500;

  typedef struct packed {
    logic [CalW-1:0] c1;
    logic [CalW-1:0] c2;
    logic [CalW-1:0] c3;
    logic [CalW-1:0] c4;
    logic [CalW-1:0] c5;
    logic [CalW-1:0] c6;
  } cal_t;

  // First-order results handed to the second-order stages
  typedef struct packed {
    logic [RawW-1:0]    d1;
    logic signed [18:0] tm;      // TEMP - 2000 before correction
    logic signed [19:0] temp_a;  // first-order temperature
    logic signed [19:0] tp;      // TEMP + 1500
    logic [17:0]        t2;
    logic signed [43:0] off1;
    logic signed [43:0] sens1;
    logic               low;
    logic               vlow;
  } first_t;

  // Corrected terms handed to the pressure stages
  typedef struct packed {
    logic [RawW-1:0]    d1;
    logic signed [46:0] off;
    logic signed [46:0] sens;
    logic signed [19:0] temp;
  } second_t;

endpackage

`default_nettype wire

/* design/bpc_first.sv */
// First-order terms: dT, TEMP, OFF, SENS over three register stages.
// Depends on bpc_pkg.
`default_nettype none

module bpc_first (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire bpc_pkg::cal_t   cal_i,
  input  wire logic            valid_i,
  input  wire logic [23:0]     d1_i,
  input  wire logic [23:0]     d2_i,
  output logic                 valid_o,
  output bpc_pkg::first_t      data_o
);
  import bpc_pkg::*;

  logic               v1_q, v2_q, v3_q;
  logic signed [24:0] dt_d, dt_q;
  logic [RawW-1:0]    d1a_q, d1b_q;
  logic signed [41:0] p6_d, p6_q, p4_d, p4_q, p3_d, p3_q;
  logic signed [49:0] pdd_d, pdd_q;
  first_t             first_d, first_q;

  always_comb begin
    dt_d = $signed({1'b0, d2_i}) - $signed({1'b0, cal_i.c5, 8'd0});
  end

  always_comb begin
    p6_d  = 42'(dt_q) * 42'($signed({1'b0, cal_i.c6}));
    p4_d  = 42'(dt_q) * 42'($signed({1'b0, cal_i.c4}));
    p3_d  = 42'(dt_q) * 42'($signed({1'b0, cal_i.c3}));
    pdd_d = 50'(dt_q) * 50'(dt_q);
  end

  always_comb begin
    first_d.d1     = d1b_q;
    first_d.tm     = $signed(p6_q[41:23]);
    first_d.temp_a = 20'(first_d.tm) + TempRef;
    first_d.tp     = first_d.temp_a - ColdLimit;
    first_d.t2     = pdd_q[48:31];
    first_d.off1   = 44'($signed({1'b0, cal_i.c2, 17'd0})) + 44'($signed(p4_q[41:6]));
    first_d.sens1  = 44'($signed({1'b0, cal_i.c1, 16'd0})) + 44'($signed(p3_q[41:7]));
    first_d.low    = first_d.tm[18];
    first_d.vlow   = first_d.temp_a < ColdLimit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dt_q    <= dt_d;
    d1a_q   <= d1_i;
    p6_q    <= p6_d;
    p4_q    <= p4_d;
    p3_q    <= p3_d;
    pdd_q   <= pdd_d;
    d1b_q   <= d1a_q;
    first_q <= first_d;
  end

  assign valid_o = v3_q;
  assign data_o  = first_q;

endmodule

`default_nettype wire

/* design/bpc_second.sv */
// Second-order low-temperature correction of TEMP, OFF and SENS.
// Three register stages; depends on bpc_pkg.
`default_nettype none

module bpc_second (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             valid_i,
  input  wire bpc_pkg::first_t  data_i,
  output logic                  valid_o,
  output bpc_pkg::second_t      data_o
);
  import bpc_pkg::*;

  logic               v4_q, v5_q, v6_q;
  first_t             f4_q;
  logic signed [37:0] tm2_q;
  logic signed [39:0] tp2_q;
  logic signed [45:0] off2_d, off2_q, sens2_d, sens2_q;
  logic signed [45:0] off_lo, off_cold, sens_lo, sens_cold;
  logic signed [19:0] temp_d, temp_q;
  logic signed [43:0] off1_q, sens1_q;
  logic [RawW-1:0]    d1_q;
  second_t            second_d, second_q;

  always_comb begin
    off_lo    = (46'(tm2_q) * 46'sd61) >>> 4;
    off_cold  = 46'(tp2_q) * 46'sd15;
    sens_lo   = 46'(tm2_q) <<< 1;
    sens_cold = 46'(tp2_q) <<< 3;
    off2_d    = '0;
    sens2_d   = '0;
    temp_d    = f4_q.temp_a;
    if (f4_q.low) begin
      off2_d  = f4_q.vlow ? off_lo + off_cold : off_lo;
      sens2_d = f4_q.vlow ? sens_lo + sens_cold : sens_lo;
      temp_d  = f4_q.temp_a - $signed({2'b00, f4_q.t2});
    end
  end

  always_comb begin
    second_d.d1   = d1_q;
    second_d.off  = 47'(off1_q) - 47'(off2_q);
    second_d.sens = 47'(sens1_q) - 47'(sens2_q);
    second_d.temp = temp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f4_q     <= data_i;
    tm2_q    <= 38'(data_i.tm) * 38'(data_i.tm);
    tp2_q    <= 40'(data_i.tp) * 40'(data_i.tp);
    off2_q   <= off2_d;
    sens2_q  <= sens2_d;
    temp_q   <= temp_d;
    off1_q   <= f4_q.off1;
    sens1_q  <= f4_q.sens1;
    d1_q     <= f4_q.d1;
    second_q <= second_d;
  end

  assign valid_o = v6_q;
  assign data_o  = second_q;

endmodule

`default_nettype wire

/* design/bpc_press.sv */
// Pressure term P = ((D1*SENS >> 21) - OFF) >> 15, product split in two halves.
// Three register stages; depends on bpc_pkg.
`default_nettype none

module bpc_press (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  input  wire bpc_pkg::second_t           data_i,
  output logic                            valid_o,
  output logic signed [bpc_pkg::PressW-1:0] pressure_o,
  output logic signed [bpc_pkg::TempW-1:0]  temp_o
);
  import bpc_pkg::*;

  logic               v7_q, v8_q, v9_q;
  logic [47:0]        pl_q;
  logic signed [47:0] ph_q;
  logic signed [46:0] off7_q, off8_q;
  logic signed [19:0] temp7_q, temp8_q;
  logic [71:0]        sum;
  logic signed [50:0] x_q;
  logic signed [51:0] diff;
  logic [PressW-1:0]  p_q;
  logic [TempW-1:0]   t_q;

  // sign-extended high half shifted over the zero-extended low half
  always_comb begin
    sum  = (72'(ph_q) << 24) + 72'(pl_q);
    diff = 52'(x_q) - 52'(off8_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      v7_q <= valid_i;
      v8_q <= v7_q;
      v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pl_q    <= 48'(data_i.d1) * 48'(data_i.sens[23:0]);
    ph_q    <= 48'($signed({1'b0, data_i.d1})) * 48'($signed(data_i.sens[46:24]));
    off7_q  <= data_i.off;
    temp7_q <= data_i.temp;
    x_q     <= $signed(sum[71:21]);
    off8_q  <= off7_q;
    temp8_q <= temp7_q;
    p_q     <= diff[46:15];
    t_q     <= temp8_q[TempW-1:0];
  end

  assign valid_o    = v9_q;
  assign pressure_o = $signed(p_q);
  assign temp_o     = $signed(t_q);

endmodule

`default_nettype wire

/* design/barometric_pressure_compensation_core.sv */
// Barometric pressure compensation core with second-order temperature correction.
// Depends on bpc_pkg, bpc_first, bpc_second, bpc_press.
//
// Usage:
//   Calibration: write words C1..C6 at indexes 0..5 on the cfg channel
//   (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i). cfg_ready_o is always
//   high; other indexes are ignored. Write only while no sample is in flight.
//   Samples: a transaction is taken on any edge with start_i high and busy_o
//   low. busy_o is always low, so one raw pressure/temperature pair can enter
//   every cycle.
//   Results: valid_o strobes for one cycle with pressure_pa_o and
//   temperature_centideg_o, in order, after the sample passes the nine-stage
//   pipeline: three stages of first-order terms, three of second-order
//   correction, three of the split D1*SENS product and final shift.
//   Throughput is one sample per cycle.
//   There is no output stall; results must be captured when strobed.
//   Reset clears the pipeline valid bits and all calibration words to zero.
`default_nettype none

module barometric_pressure_compensation_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bpc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [bpc_pkg::CalW-1:0]       cfg_data_i,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic [bpc_pkg::RawW-1:0]       raw_pressure_i,
  input  wire logic [bpc_pkg::RawW-1:0]       raw_temperature_i,
  output logic                                valid_o,
  output logic signed [bpc_pkg::PressW-1:0]   pressure_pa_o,
  output logic signed [bpc_pkg::TempW-1:0]    temperature_centideg_o
);
  import bpc_pkg::*;

  cal_t    cal_d, cal_q;
  logic    accept;
  logic    first_valid, second_valid;
  first_t  first_data;
  second_t second_data;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;
  assign accept      = start_i & ~busy_o;

  always_comb begin
    cal_d = cal_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegSens:     cal_d.c1 = cfg_data_i;
        RegOff:      cal_d.c2 = cfg_data_i;
        RegSensTco:  cal_d.c3 = cfg_data_i;
        RegOffTco:   cal_d.c4 = cfg_data_i;
        RegTref:     cal_d.c5 = cfg_data_i;
        RegTempCoef: cal_d.c6 = cfg_data_i;
        default:     cal_d = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  bpc_first u_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cal_i   (cal_q),
    .valid_i (accept),
    .d1_i    (raw_pressure_i),
    .d2_i    (raw_temperature_i),
    .valid_o (first_valid),
    .data_o  (first_data)
  );

  bpc_second u_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (first_valid),
    .data_i  (first_data),
    .valid_o (second_valid),
    .data_o  (second_data)
  );

  bpc_press u_press (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (second_valid),
    .data_i     (second_data),
    .valid_o    (valid_o),
    .pressure_o (pressure_pa_o),
    .temp_o     (temperature_centideg_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_barometric_pressure_compensation_core.sv */
// Self-checking testbench for barometric_pressure_compensation_core.
// Depends on bpc_pkg and the core; predicts each compensated reading from the
// raw sample pair and the calibration words, then checks every strobed result.
module tb_barometric_pressure_compensation_core;
  import bpc_pkg::*;

  localparam int unsigned PhaseSamples   = 214;
  localparam int unsigned RandomPhases   = 6;
  localparam int unsigned DrainCycles    = 24;
  localparam int unsigned WatchdogLimit  = 1000;
  localparam logic [RawW-1:0] RawMax     = {RawW{1'b1}};
  // indexes past the last calibration word; writes to them must be dropped
  localparam logic [CfgIdxW-1:0] IdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] IdxSpareHi = 3'd7;

  typedef struct {
    logic [RawW-1:0] d1;
    logic [RawW-1:0] d2;
  } sample_t;

  typedef struct {
    logic signed [PressW-1:0] pressure;
    logic signed [TempW-1:0]  temp_cd;
  } reading_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i = '0;
  logic [CalW-1:0]          cfg_data_i = '0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic [RawW-1:0]          raw_pressure_i = '0;
  logic [RawW-1:0]          raw_temperature_i = '0;
  logic                     valid_o;
  logic signed [PressW-1:0] pressure_pa_o;
  logic signed [TempW-1:0]  temperature_centideg_o;

  cal_t        cal_words = '0;
  sample_t     pending_samples[$];
  reading_t    expected_readings[$];
  int unsigned send_idle_pct = 32;
  int unsigned samples_queued = 0;
  int unsigned samples_taken = 0;
  int unsigned readings_checked = 0;
  int unsigned cal_writes = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;

  barometric_pressure_compensation_core u_top (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .cfg_ready_o           (cfg_ready_o),
    .cfg_index_i           (cfg_index_i),
    .cfg_data_i            (cfg_data_i),
    .start_i               (start_i),
    .busy_o                (busy_o),
    .raw_pressure_i        (raw_pressure_i),
    .raw_temperature_i     (raw_temperature_i),
    .valid_o               (valid_o),
    .pressure_pa_o         (pressure_pa_o),
    .temperature_centideg_o(temperature_centideg_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Second-order compensation, all intermediates at 64 bits; >>> floors.
  function automatic reading_t compensate_sample(input logic [RawW-1:0] d1,
                                                 input logic [RawW-1:0] d2,
                                                 input cal_t cal);
    longint   pd1, dt, temp, off, sens, tm, tp, off2, sens2, p;
    reading_t r;
    pd1  = longint'(d1);
    dt   = longint'(d2) - longint'(cal.c5) * 256;
    temp = TempRef + ((dt * longint'(cal.c6)) >>> 23);
    off  = longint'(cal.c2) * 131072 + ((longint'(cal.c4) * dt) >>> 6);
    sens = longint'(cal.c1) * 65536 + ((longint'(cal.c3) * dt) >>> 7);
    if (temp < TempRef) begin
      tm    = temp - TempRef;
      off2  = (61 * tm * tm) >>> 4;
      sens2 = 2 * tm * tm;
      if (temp < ColdLimit) begin
        tp    = temp - ColdLimit;
        off2  = off2 + 15 * tp * tp;
        sens2 = sens2 + 8 * tp * tp;
      end
      temp = temp - ((dt * dt) >>> 31);
      off  = off - off2;
      sens = sens - sens2;
    end
    p = (((pd1 * sens) >>> 21) - off) >>> 15;
    r.pressure = p[PressW-1:0];
    r.temp_cd  = temp[TempW-1:0];
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    $display("%s", msg);
  endtask

  task automatic queue_sample(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
    sample_t s;
    s.d1 = d1;
    s.d2 = d2;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // Returns once every queued sample was taken and its reading checked.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (samples_taken != samples_queued || readings_checked != samples_taken);
  endtask

  task automatic write_cal(input logic [CfgIdxW-1:0] idx, input logic [CalW-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i);
    while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegSens:     cal_words.c1 = data;
      RegOff:      cal_words.c2 = data;
      RegSensTco:  cal_words.c3 = data;
      RegOffTco:   cal_words.c4 = data;
      RegTref:     cal_words.c5 = data;
      RegTempCoef: cal_words.c6 = data;
      default: ;
    endcase
    cal_writes++;
  endtask

  task automatic load_calibration(input cal_t cal);
    write_cal(RegSens, cal.c1);
    write_cal(RegOff, cal.c2);
    write_cal(RegSensTco, cal.c3);
    write_cal(RegOffTco, cal.c4);
    write_cal(RegTref, cal.c5);
    write_cal(RegTempCoef, cal.c6);
  endtask

  // Sample driver: the transaction on the ports is taken when start is high
  // and busy is low; only then is the next one loaded.
  always @(posedge clk_i) begin
    sample_t nxt;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        expected_readings.push_back(
          compensate_sample(raw_pressure_i, raw_temperature_i, cal_words));
        samples_taken++;
      end
      if (!start_i || !busy_o) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_samples.pop_front();
          raw_pressure_i    <= nxt.d1;
          raw_temperature_i <= nxt.d2;
          start_i           <= 1'b1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (expected_readings.size() == 0) begin
        flag_error($sformatf("%0t: unexpected reading pressure %0d temperature %0d",
                             $time, pressure_pa_o, temperature_centideg_o));
      end else begin
        want = expected_readings.pop_front();
        if (pressure_pa_o !== want.pressure)
          flag_error($sformatf("%0t: pressure_pa expected %0d, got %0d",
                               $time, want.pressure, pressure_pa_o));
        if (temperature_centideg_o !== want.temp_cd)
          flag_error($sformatf("%0t: temperature_centideg expected %0d, got %0d",
                               $time, want.temp_cd, temperature_centideg_o));
        readings_checked++;
      end
    end
  end

  // Watchdog: any accepted transaction on any channel resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || valid_o === 1'b1 || (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no transaction for %0d cycles, %0d readings outstanding",
                 $time, WatchdogLimit, samples_queued - readings_checked);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    cal_t        cal;
    longint      tref_code, d2v;
    int unsigned phase, n, k;
    logic [RawW-1:0] d1v;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // calibration never written: all words read as zero
    queue_sample('0, '0);
    queue_sample(RawMax, RawMax);
    wait_drained();

    cal = '{c1: 16'd41000, c2: 16'd37500, c3: 16'd24000, c4: 16'd22800,
            c5: 16'd32900, c6: 16'd27500};
    load_calibration(cal);
    write_cal(IdxSpareLo, '1);
    write_cal(IdxSpareHi, 16'h5a5a);
    tref_code = longint'(cal_words.c5) * 256;
    queue_sample(24'd8500000, 24'd8430000);
    queue_sample(24'd6400000, RawW'(tref_code));          // exactly 20.00 degC
    queue_sample(24'd6400000, RawW'(tref_code - 1));      // just below 20.00 degC
    // -15.00 degC exactly, then one step colder
    queue_sample(24'd6400000,
                 RawW'(tref_code - (64'sd3500 << 23) / longint'(cal_words.c6)));
    queue_sample(24'd6400000,
                 RawW'(tref_code - (64'sd3501 << 23) / longint'(cal_words.c6)));
    queue_sample(24'd6400000, '0);
    queue_sample(24'd6400000, RawMax);
    queue_sample('0, 24'd5000000);
    queue_sample(RawMax, 24'd5000000);
    wait_drained();

    load_calibration('1);
    queue_sample('0, '0);
    queue_sample(RawMax, RawMax);
    queue_sample(RawMax, '0);
    queue_sample('0, RawMax);
    queue_sample(24'h800000, 24'h800000);
    wait_drained();

    for (phase = 0; phase < RandomPhases; phase++) begin
      send_idle_pct = (phase < 2) ? 32 : (phase < 4) ? 74 : 0;
      for (k = 0; k < 6; k++) begin
        case ($urandom_range(7))
          0:       cal[k*CalW +: CalW] = '0;
          1:       cal[k*CalW +: CalW] = '1;
          default: cal[k*CalW +: CalW] = CalW'($urandom);
        endcase
      end
      if (phase == 1) cal = '1;
      load_calibration(cal);
      if ($urandom_range(1))
        write_cal($urandom_range(1) ? IdxSpareLo : IdxSpareHi, CalW'($urandom));
      tref_code = longint'(cal_words.c5) * 256;
      for (n = 0; n < PhaseSamples; n++) begin
        case ($urandom_range(9))
          0:       d1v = '0;
          1:       d1v = RawMax;
          default: d1v = RawW'($urandom);
        endcase
        // nearly half near the reference reading so all temperature bands are hit
        case ($urandom_range(9))
          8:       d2v = 0;
          9:       d2v = longint'(RawMax);
          default: begin
            if ($urandom_range(9) < 4)
              d2v = longint'($urandom_range(RawMax));
            else
              d2v = tref_code + longint'($urandom_range(1 << 22)) - (1 << 21);
          end
        endcase
        if (d2v < 0) d2v = 0;
        if (d2v > longint'(RawMax)) d2v = longint'(RawMax);
        queue_sample(d1v, d2v[RawW-1:0]);
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    $display("Checked %0d readings from %0d samples; %0d calibration writes",
             readings_checked, samples_taken, cal_writes);
    $display("Covered unset, typical, all-ones and %0d random calibration sets", RandomPhases);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d errors", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
